// ----- src/lrg_pkg.sv -----
// Shared types and constants for the linear resampler with gain.
// Holds the sequencer state type, register indexes and datapath widths.
// No dependencies.
package lrg_pkg;

   localparam int PCM_W   = 16;
   localparam int RATE_W  = 18;
   localparam int PHASE_W = 22;
   localparam int P_W     = 23;
   localparam int GAIN_W  = 16;
   localparam int ACC_W   = 35;
   localparam int REM_W   = 18;
   localparam int DCNT_W  = 5;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [1:0] REG_SOURCE_RATE = 2'd0;
   localparam logic [1:0] REG_TARGET_RATE = 2'd1;
   localparam logic [1:0] REG_STEREO_IN   = 2'd2;
   localparam logic [1:0] REG_GAIN_Q12    = 2'd3;

   localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd22050;
   localparam logic [RATE_W-1:0] TARGET_RATE_RST = 18'd16000;
   localparam logic [GAIN_W-1:0] GAIN_RST        = 16'd4096;
   localparam logic [GAIN_W-1:0] GAIN_UNITY_LO   = 16'd4092;
   localparam logic [GAIN_W-1:0] GAIN_UNITY_HI   = 16'd4100;

   localparam logic [PCM_W-1:0] PCM_MAX = 16'h7FFF;
   localparam logic [PCM_W-1:0] PCM_MIN = 16'h8000;

   localparam logic [DCNT_W-1:0] DIV_STEPS_INTERP = 5'd16;
   localparam logic [DCNT_W-1:0] DIV_STEPS_CEIL   = 5'd18;

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_SEG_CHK  = 11'b000_0000_0010,
      ST_MUL_A    = 11'b000_0000_0100,
      ST_MUL_B    = 11'b000_0000_1000,
      ST_DIV_INIT = 11'b000_0001_0000,
      ST_DIV_STEP = 11'b000_0010_0000,
      ST_DIV_FIN  = 11'b000_0100_0000,
      ST_G_MUL    = 11'b000_1000_0000,
      ST_G_OUT    = 11'b001_0000_0000,
      ST_FIN_CHK  = 11'b010_0000_0000,
      ST_END      = 11'b100_0000_0000
   } state_type;

endpackage

// ----- src/linear_resampler_with_gain.sv -----
// Linear-interpolation sample rate converter with Q4.12 output gain; depends on lrg_pkg.
// Each interpolated result takes two multiplies, a 16-step divide and a gain multiply.
// Outputs past MAX_UPSAMPLE per interval are skipped by an 18-step divide that sets the phase.
// A final item closes a last interval; equal rates bypass interpolation and apply only gain.
// One item in flight; output stalls hold the sequencer.
// Synchronous active-high reset: registers to defaults, stream state cleared, no result pending.
module linear_resampler_with_gain
   import lrg_pkg::*;
#(
   parameter int MAX_UPSAMPLE = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [PCM_W-1:0] req_pcm_in,
   input  logic                    req_final_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [PCM_W-1:0] rsp_pcm_out,
   output logic                    rsp_pcm_valid,
   output logic                    rsp_stream_end,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_W-1:0]       csr_paddr,
   input  logic [DATA_W-1:0]       csr_pwdata,
   output logic [DATA_W-1:0]       csr_prdata,
   output logic                    csr_pready
);

   localparam int CNT_W = $clog2(MAX_UPSAMPLE + 1);

   logic [RATE_W-1:0] src_rate_ff;
   logic [RATE_W-1:0] tgt_rate_ff;
   logic              stereo_ff;
   logic [GAIN_W-1:0] gain_ff;

   state_type                state_ff, state_in;
   logic signed [PCM_W-1:0]  prev_ff, prev_in;
   logic                     have_prev_ff, have_prev_in;
   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic                     toggle_ff, toggle_in;
   logic                     fin_ff, fin_in;
   logic                     final_seg_ff, final_seg_in;
   logic                     seg_ctx_ff, seg_ctx_in;
   logic                     ceil_ff, ceil_in;
   logic                     neg_ff, neg_in;
   logic signed [PCM_W-1:0]  seg_a_ff, seg_a_in;
   logic signed [PCM_W-1:0]  seg_b_ff, seg_b_in;
   logic signed [PCM_W-1:0]  v_ff, v_in;
   logic [P_W-1:0]           p_ff, p_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [RATE_W-1:0]        dvd_ff, dvd_in;
   logic [RATE_W-1:0]        div_ff, div_in;
   logic [DCNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic signed [PCM_W-1:0]  hold_pcm_ff, hold_pcm_in;
   logic                     hold_vld_ff, hold_vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [PCM_W-1:0]  rsp_pcm_ff, rsp_pcm_in;
   logic                     rsp_pvld_ff, rsp_pvld_in;
   logic                     rsp_end_ff, rsp_end_in;

   logic [RATE_W-1:0]        s_eff, t_eff, t_minus_p;
   logic                     rate_bypass, gain_bypass, out_free, p_lt_t, cnt_ok;
   logic signed [PCM_W-1:0]  mul_a;
   logic [RATE_W-1:0]        mul_b;
   logic signed [RATE_W:0]   mul_b_s;
   logic signed [ACC_W-1:0]  product;
   logic [ACC_W-1:0]         acc_mag;
   logic signed [ACC_W-1:0]  gsum, gshift;
   logic signed [PCM_W-1:0]  gain_res;
   logic [REM_W:0]           step_r2;
   logic                     step_ge;
   logic [REM_W-1:0]         step_rem;
   logic [RATE_W-1:0]        step_dvd;
   logic [PCM_W-1:0]         quot;
   logic                     csr_wr;

   // configuration registers
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_rate_ff <= SOURCE_RATE_RST;
         tgt_rate_ff <= TARGET_RATE_RST;
         stereo_ff   <= 1'b0;
         gain_ff     <= GAIN_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_SOURCE_RATE: src_rate_ff <= csr_pwdata[RATE_W-1:0];
            REG_TARGET_RATE: tgt_rate_ff <= csr_pwdata[RATE_W-1:0];
            REG_STEREO_IN:   stereo_ff   <= csr_pwdata[0];
            REG_GAIN_Q12:    gain_ff     <= csr_pwdata[GAIN_W-1:0];
            default:         src_rate_ff <= src_rate_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_SOURCE_RATE: csr_prdata = DATA_W'(src_rate_ff);
         REG_TARGET_RATE: csr_prdata = DATA_W'(tgt_rate_ff);
         REG_STEREO_IN:   csr_prdata = DATA_W'(stereo_ff);
         REG_GAIN_Q12:    csr_prdata = DATA_W'(gain_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // shared datapath
   assign s_eff       = (src_rate_ff == '0) ? RATE_W'(1) : src_rate_ff;
   assign t_eff       = (tgt_rate_ff == '0) ? RATE_W'(1) : tgt_rate_ff;
   assign rate_bypass = (s_eff == t_eff);
   assign gain_bypass = (gain_ff >= GAIN_UNITY_LO) && (gain_ff <= GAIN_UNITY_HI);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign p_lt_t      = p_ff < P_W'(t_eff);
   assign cnt_ok      = cnt_ff < CNT_W'(MAX_UPSAMPLE);
   assign t_minus_p   = t_eff - p_ff[RATE_W-1:0];

   always_comb begin
      case (state_ff)
         ST_MUL_A: begin
            mul_a = seg_a_ff;
            mul_b = t_minus_p;
         end
         ST_MUL_B: begin
            mul_a = seg_b_ff;
            mul_b = p_ff[RATE_W-1:0];
         end
         default: begin
            mul_a = v_ff;
            mul_b = RATE_W'(gain_ff);
         end
      endcase
   end

   assign mul_b_s = $signed({1'b0, mul_b});
   assign product = mul_a * mul_b_s;

   assign acc_mag = acc_ff[ACC_W-1] ? (~acc_ff + ACC_W'(1)) : acc_ff;

   // truncate toward zero, then saturate
   assign gsum   = acc_ff + $signed({{(ACC_W-12){1'b0}}, {12{acc_ff[ACC_W-1]}}});
   assign gshift = gsum >>> 12;

   always_comb begin
      if (gain_bypass) begin
         gain_res = v_ff;
      end else if (gshift > $signed({{(ACC_W-PCM_W){1'b0}}, PCM_MAX})) begin
         gain_res = $signed(PCM_MAX);
      end else if (gshift < $signed({{(ACC_W-PCM_W){1'b1}}, PCM_MIN})) begin
         gain_res = $signed(PCM_MIN);
      end else begin
         gain_res = gshift[PCM_W-1:0];
      end
   end

   assign step_r2  = {rem_ff, dvd_ff[RATE_W-1]};
   assign step_ge  = step_r2 >= {1'b0, div_ff};
   assign step_rem = step_ge ? REM_W'(step_r2 - {1'b0, div_ff}) : step_r2[REM_W-1:0];
   assign step_dvd = {dvd_ff[RATE_W-2:0], step_ge};
   assign quot     = dvd_ff[PCM_W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      toggle_in    = toggle_ff;
      fin_in       = fin_ff;
      final_seg_in = final_seg_ff;
      seg_ctx_in   = seg_ctx_ff;
      ceil_in      = ceil_ff;
      neg_in       = neg_ff;
      seg_a_in     = seg_a_ff;
      seg_b_in     = seg_b_ff;
      v_in         = v_ff;
      p_in         = p_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      div_in       = div_ff;
      div_cnt_in   = div_cnt_ff;
      hold_pcm_in  = hold_pcm_ff;
      hold_vld_in  = hold_vld_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pcm_in   = rsp_pcm_ff;
      rsp_pvld_in  = rsp_pvld_ff;
      rsp_end_in   = rsp_end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               fin_in    = req_final_in;
               toggle_in = stereo_ff && !toggle_ff;
               if (!stereo_ff || !toggle_ff) begin
                  prev_in      = req_pcm_in;
                  have_prev_in = 1'b1;
                  if (rate_bypass) begin
                     v_in       = req_pcm_in;
                     seg_ctx_in = 1'b0;
                     state_in   = ST_G_MUL;
                  end else if (have_prev_ff) begin
                     seg_a_in     = prev_ff;
                     seg_b_in     = req_pcm_in;
                     p_in         = P_W'(phase_ff);
                     cnt_in       = '0;
                     final_seg_in = 1'b0;
                     seg_ctx_in   = 1'b1;
                     state_in     = ST_SEG_CHK;
                  end else begin
                     phase_in = '0;
                     state_in = ST_FIN_CHK;
                  end
               end else begin
                  state_in = ST_FIN_CHK;
               end
            end
         end
         ST_SEG_CHK: begin
            if (p_lt_t && cnt_ok) begin
               state_in = ST_MUL_A;
            end else if (p_lt_t) begin
               // skip the excess outputs: new phase from (t - p) mod s
               rem_in     = '0;
               dvd_in     = t_minus_p;
               div_in     = s_eff;
               div_cnt_in = DIV_STEPS_CEIL;
               ceil_in    = 1'b1;
               state_in   = ST_DIV_STEP;
            end else begin
               phase_in = PHASE_W'(p_ff - P_W'(t_eff));
               state_in = final_seg_ff ? ST_END : ST_FIN_CHK;
            end
         end
         ST_MUL_A: begin
            acc_in   = product;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            acc_in   = acc_ff + product;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            neg_in     = acc_ff[ACC_W-1];
            rem_in     = REM_W'(acc_mag[32:16]);
            dvd_in     = {acc_mag[PCM_W-1:0], 2'b00};
            div_in     = t_eff;
            div_cnt_in = DIV_STEPS_INTERP;
            ceil_in    = 1'b0;
            state_in   = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            rem_in     = step_rem;
            dvd_in     = step_dvd;
            div_cnt_in = div_cnt_ff - DCNT_W'(1);
            if (div_cnt_ff == DCNT_W'(1)) begin
               state_in = ST_DIV_FIN;
            end
         end
         ST_DIV_FIN: begin
            if (ceil_ff) begin
               phase_in = (rem_ff == '0) ? '0 : PHASE_W'(s_eff - rem_ff);
               state_in = final_seg_ff ? ST_END : ST_FIN_CHK;
            end else begin
               v_in     = neg_ff ? $signed(~quot + PCM_W'(1)) : $signed(quot);
               state_in = ST_G_MUL;
            end
         end
         ST_G_MUL: begin
            acc_in   = product;
            state_in = ST_G_OUT;
         end
         ST_G_OUT: begin
            if (!hold_vld_ff || out_free) begin
               if (hold_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_pcm_in   = hold_pcm_ff;
                  rsp_pvld_in  = 1'b1;
                  rsp_end_in   = 1'b0;
               end
               hold_pcm_in = gain_res;
               hold_vld_in = 1'b1;
               if (seg_ctx_ff) begin
                  p_in     = p_ff + P_W'(s_eff);
                  cnt_in   = cnt_ff + CNT_W'(1);
                  state_in = ST_SEG_CHK;
               end else begin
                  state_in = ST_FIN_CHK;
               end
            end
         end
         ST_FIN_CHK: begin
            if (fin_ff && !rate_bypass && have_prev_ff) begin
               seg_a_in     = prev_ff;
               seg_b_in     = prev_ff;
               p_in         = P_W'(phase_ff);
               cnt_in       = '0;
               final_seg_in = 1'b1;
               seg_ctx_in   = 1'b1;
               state_in     = ST_SEG_CHK;
            end else begin
               state_in = ST_END;
            end
         end
         ST_END: begin
            if (fin_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pcm_in   = hold_vld_ff ? hold_pcm_ff : '0;
                  rsp_pvld_in  = hold_vld_ff;
                  rsp_end_in   = 1'b1;
                  hold_vld_in  = 1'b0;
                  prev_in      = '0;
                  have_prev_in = 1'b0;
                  phase_in     = '0;
                  toggle_in    = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pcm_in   = hold_pcm_ff;
               rsp_pvld_in  = 1'b1;
               rsp_end_in   = 1'b0;
               hold_vld_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         toggle_ff    <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         toggle_ff    <= toggle_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff       <= fin_in;
      final_seg_ff <= final_seg_in;
      seg_ctx_ff   <= seg_ctx_in;
      ceil_ff      <= ceil_in;
      neg_ff       <= neg_in;
      seg_a_ff     <= seg_a_in;
      seg_b_ff     <= seg_b_in;
      v_ff         <= v_in;
      p_ff         <= p_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      div_ff       <= div_in;
      hold_pcm_ff  <= hold_pcm_in;
      rsp_pcm_ff   <= rsp_pcm_in;
      rsp_pvld_ff  <= rsp_pvld_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pcm_out    = rsp_pcm_ff;
   assign rsp_pcm_valid  = rsp_pvld_ff;
   assign rsp_stream_end = rsp_end_ff;

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_vld_ff)
      else $error("item held while idle");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_UPSAMPLE))
      else $error("output count past upsample limit");

   a_div_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_STEP) |-> (div_cnt_ff != '0))
      else $error("divider running with no steps left");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_END && fin_ff && out_free) |=> (!have_prev_ff && rsp_stream_end))
      else $error("stream end did not close the stream");

endmodule
